// ----- sv/dnsrap_pkg.sv -----
// Package for the DNS response address parser: types and fixed constants.
package dnsrap_pkg;

   // Parser phases, one-hot.
   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_QNAME  = 6'b000010,
      PH_QTAIL  = 6'b000100,
      PH_ANSWER = 6'b001000,
      PH_RDATA  = 6'b010000,
      PH_DONE   = 6'b100000
   } dnsrap_phase_type;

   localparam logic       KIND_ADDRESS = 1'b0;
   localparam logic       KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_TRUNC = 2'd2;

   // Byte positions within the fixed parts of the message.
   localparam logic [3:0] HEADER_LAST_POS = 4'd11;
   localparam logic [3:0] COUNT_HI_POS    = 4'd6;
   localparam logic [3:0] COUNT_LO_POS    = 4'd7;
   localparam logic [3:0] QTAIL_LAST_POS  = 4'd3;
   localparam logic [3:0] ANSWER_LAST_POS = 4'd11;
   localparam logic [3:0] ADDRESS_LEN     = 4'd4;
   localparam logic [3:0] POS_SATURATED   = 4'hF;

   localparam logic [15:0] CLASS_IN = 16'd1;
   localparam logic [15:0] TYPE_A   = 16'd1;

   // Results caused by one accepted byte.
   typedef struct packed {
      logic        addr_valid;
      logic [31:0] address;
      logic [31:0] ttl;
      logic [15:0] rtype;
      logic        sum_valid;
      logic [15:0] answers;
      logic [1:0]  status;
   } dnsrap_run_type;

endpackage

// ----- sv/dnsrap_if.sv -----
// Valid/ready channel interfaces for message bytes and parse results.
interface dnsrap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface dnsrap_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [31:0] ipv4_address;
   logic [31:0] time_to_live;
   logic [15:0] record_type;
   logic [15:0] answers_announced;
   logic [1:0]  parse_status;
   logic        last_of_run;

   modport source (output valid, output result_kind, output ipv4_address,
                   output time_to_live, output record_type, output answers_announced,
                   output parse_status, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input ipv4_address,
                   input time_to_live, input record_type, input answers_announced,
                   input parse_status, input last_of_run, output ready);
endinterface

// ----- sv/dnsrap_front.sv -----
// Front end: accepts message bytes, runs the parse state and forms result runs.
module dnsrap_front (
   input  logic                     clock,
   input  logic                     reset,
   dnsrap_req_if.sink               req_if,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   input  logic                     queue_full,
   output logic                     push,
   output dnsrap_pkg::dnsrap_run_type push_run
);

   dnsrap_pkg::dnsrap_phase_type phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  label_ff, label_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] class_ff, class_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [15:0] rdlen_ff, rdlen_in;
   logic [31:0] addr_ff, addr_in;
   logic        type_a_ff;

   logic        accept;
   logic        emit_addr;
   logic [7:0]  b;
   logic [15:0] left_dec;
   logic [15:0] rdlen_dec;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.data_byte;
   assign left_dec     = left_ff - 16'd1;
   assign rdlen_dec    = rdlen_ff - 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      label_in  = label_ff;
      total_in  = total_ff;
      left_in   = left_ff;
      type_in   = type_ff;
      class_in  = class_ff;
      ttl_in    = ttl_ff;
      rdlen_in  = rdlen_ff;
      addr_in   = addr_ff;
      emit_addr = 1'b0;
      push_run  = '0;

      case (phase_ff)
         dnsrap_pkg::PH_HEADER: begin
            if (pos_ff == dnsrap_pkg::COUNT_HI_POS) begin
               total_in = {b, 8'h00};
            end else if (pos_ff == dnsrap_pkg::COUNT_LO_POS) begin
               total_in = {total_ff[15:8], b};
            end
            if (pos_ff == dnsrap_pkg::HEADER_LAST_POS) begin
               left_in  = total_in;
               pos_in   = '0;
               label_in = '0;
               phase_in = dnsrap_pkg::PH_QNAME;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
         dnsrap_pkg::PH_QNAME: begin
            if (label_ff == 8'd0) begin
               if (b == 8'd0) begin
                  pos_in   = '0;
                  phase_in = dnsrap_pkg::PH_QTAIL;
               end else begin
                  label_in = b;
               end
            end else begin
               label_in = label_ff - 8'd1;
            end
         end
         dnsrap_pkg::PH_QTAIL: begin
            if (pos_ff == dnsrap_pkg::QTAIL_LAST_POS) begin
               pos_in   = '0;
               phase_in = (left_ff == 16'd0) ? dnsrap_pkg::PH_DONE : dnsrap_pkg::PH_ANSWER;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
         dnsrap_pkg::PH_ANSWER: begin
            case (pos_ff) inside
               4'd2, 4'd3:    type_in  = {type_ff[7:0], b};
               4'd4, 4'd5:    class_in = {class_ff[7:0], b};
               [4'd6:4'd9]:   ttl_in   = {ttl_ff[23:0], b};
               4'd10, 4'd11:  rdlen_in = {rdlen_ff[7:0], b};
               default:       ;
            endcase
            if (pos_ff == dnsrap_pkg::ANSWER_LAST_POS) begin
               pos_in  = '0;
               addr_in = '0;
               if (rdlen_in == 16'd0) begin
                  left_in  = left_dec;
                  phase_in = (left_dec == 16'd0) ? dnsrap_pkg::PH_DONE
                                                 : dnsrap_pkg::PH_ANSWER;
               end else begin
                  phase_in = dnsrap_pkg::PH_RDATA;
               end
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
         dnsrap_pkg::PH_RDATA: begin
            if (pos_ff < dnsrap_pkg::ADDRESS_LEN) begin
               addr_in = {addr_ff[23:0], b};
            end
            // The position only needs to tell short, exact and long data apart.
            if (pos_ff != dnsrap_pkg::POS_SATURATED) begin
               pos_in = pos_ff + 4'd1;
            end
            rdlen_in = rdlen_dec;
            if (rdlen_dec == 16'd0) begin
               emit_addr = (pos_in == dnsrap_pkg::ADDRESS_LEN) &&
                           (class_ff == dnsrap_pkg::CLASS_IN) &&
                           (!type_a_ff || (type_ff == dnsrap_pkg::TYPE_A));
               left_in  = left_dec;
               pos_in   = '0;
               phase_in = (left_dec == 16'd0) ? dnsrap_pkg::PH_DONE
                                              : dnsrap_pkg::PH_ANSWER;
            end
         end
         dnsrap_pkg::PH_DONE: begin
            phase_in = dnsrap_pkg::PH_DONE;
         end
         default: begin
            phase_in = dnsrap_pkg::PH_DONE;
         end
      endcase

      push_run.addr_valid = emit_addr;
      push_run.address    = addr_in;
      push_run.ttl        = ttl_ff;
      push_run.rtype      = type_ff;

      if (req_if.end_of_message) begin
         push_run.sum_valid = 1'b1;
         push_run.answers   = total_in;
         if (phase_in == dnsrap_pkg::PH_HEADER) begin
            push_run.status = dnsrap_pkg::STATUS_SHORT;
         end else if (phase_in == dnsrap_pkg::PH_DONE) begin
            push_run.status = dnsrap_pkg::STATUS_OK;
         end else begin
            push_run.status = dnsrap_pkg::STATUS_TRUNC;
         end
         // The summary ends the message: the parse restarts from reset values.
         phase_in = dnsrap_pkg::PH_HEADER;
         pos_in   = '0;
         label_in = '0;
         total_in = '0;
         left_in  = '0;
         type_in  = '0;
         class_in = '0;
         ttl_in   = '0;
         rdlen_in = '0;
         addr_in  = '0;
      end
   end

   assign push = accept && (emit_addr || req_if.end_of_message);

   always_ff @(posedge clock) begin
      if (reset) begin
         type_a_ff <= 1'b0;
      end else if (csr_write_enable) begin
         type_a_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dnsrap_pkg::PH_HEADER;
         pos_ff   <= '0;
         label_ff <= '0;
         total_ff <= '0;
         left_ff  <= '0;
         type_ff  <= '0;
         class_ff <= '0;
         ttl_ff   <= '0;
         rdlen_ff <= '0;
         addr_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         label_ff <= label_in;
         total_ff <= total_in;
         left_ff  <= left_in;
         type_ff  <= type_in;
         class_ff <= class_in;
         ttl_ff   <= ttl_in;
         rdlen_ff <= rdlen_in;
         addr_ff  <= addr_in;
      end
   end

endmodule

// ----- sv/dnsrap_queue.sv -----
// Short queue of result runs between the front end and the result sequencer.
module dnsrap_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dnsrap_pkg::dnsrap_run_type push_run,
   input  logic                      pop,
   output logic                      full,
   output logic                      head_valid,
   output dnsrap_pkg::dnsrap_run_type head_run
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dnsrap_pkg::dnsrap_run_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_run   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/dnsrap_back.sv -----
// Back end: delivers the one or two results of each queued run in order.
module dnsrap_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  dnsrap_pkg::dnsrap_run_type head_run,
   output logic                      pop,
   dnsrap_rsp_if.source              rsp_if
);

   logic second_ff, second_in;
   logic show_addr;
   logic handshake;

   // The address result of a run always goes out before its summary.
   assign show_addr = head_run.addr_valid && !second_ff;
   assign handshake = rsp_if.valid && rsp_if.ready;
   assign pop       = handshake && !(show_addr && head_run.sum_valid);

   always_comb begin
      rsp_if.valid = head_valid;
      if (show_addr) begin
         rsp_if.result_kind       = dnsrap_pkg::KIND_ADDRESS;
         rsp_if.ipv4_address      = head_run.address;
         rsp_if.time_to_live      = head_run.ttl;
         rsp_if.record_type       = head_run.rtype;
         rsp_if.answers_announced = '0;
         rsp_if.parse_status      = dnsrap_pkg::STATUS_OK;
         rsp_if.last_of_run       = !head_run.sum_valid;
      end else begin
         rsp_if.result_kind       = dnsrap_pkg::KIND_SUMMARY;
         rsp_if.ipv4_address      = '0;
         rsp_if.time_to_live      = '0;
         rsp_if.record_type       = '0;
         rsp_if.answers_announced = head_run.answers;
         rsp_if.parse_status      = head_run.status;
         rsp_if.last_of_run       = 1'b1;
      end
   end

   always_comb begin
      second_in = second_ff;
      if (pop) begin
         second_in = 1'b0;
      end else if (handshake) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// ----- sv/dns_response_address_parser.sv -----
// A byte's results are registered in the queue before they reach rsp.
// Throughput: one byte per cycle while the queue has room; results leave at one per cycle
// while rsp is ready, so an address and a summary from one byte go out one after the other.
// A queue of QUEUE_DEPTH result runs lets the byte side keep going while results stall.
// Reset is synchronous and active high: it restarts the parse, empties the queue and
// clears the type-A filter bit (type_a_ff).
module dns_response_address_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   dnsrap_req_if.sink    req_if,
   dnsrap_rsp_if.source  rsp_if,
   input  logic          csr_write_enable,
   input  logic          csr_write_data
);

   logic                       push;
   dnsrap_pkg::dnsrap_run_type push_run;
   logic                       queue_full;
   logic                       pop;
   logic                       head_valid;
   dnsrap_pkg::dnsrap_run_type head_run;

   dnsrap_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_run         (push_run)
   );

   dnsrap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   dnsrap_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

   // A summary always closes the run of its byte.
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.result_kind == dnsrap_pkg::KIND_SUMMARY) |-> rsp_if.last_of_run)
      else $error("summary result without last_of_run");

   // An address that is not last in its run is followed at once by the summary.
   a_addr_then_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.result_kind == dnsrap_pkg::KIND_ADDRESS &&
       !rsp_if.last_of_run)
      |=> (rsp_if.valid && rsp_if.result_kind == dnsrap_pkg::KIND_SUMMARY))
      else $error("address result not followed by its summary");

   // The final byte of a message always leaves a result waiting.
   a_eom_yields_result: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.end_of_message) |=> rsp_if.valid)
      else $error("end of message produced no result");

   // On an address result, the summary fields stay zero.
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.result_kind == dnsrap_pkg::KIND_ADDRESS)
      |-> (rsp_if.answers_announced == 16'd0 &&
           rsp_if.parse_status == dnsrap_pkg::STATUS_OK))
      else $error("address result carries summary fields");

endmodule
